// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame buffer RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/mpfb_pkg.sv =====
// Shared types and constants of the page-mode monochrome frame buffer.
// No dependencies; used by the controller, the datapath and the top level.
package mpfb_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_LAYERS_DEF = 256;

  localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

  // Register index as decoded from paddr bit 2.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DECLARE = 2'd1,
    OP_DRAW    = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OUTSIDE   = 2'd1,
    STS_INVISIBLE = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic capture;  // register the item and issue the memory reads
    logic finish;   // write back and load the result register
    logic sweep;    // write zero at the sweep address
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic op_clear;
    logic sweep_last;
  } dp_status_t;

endpackage

// ===== hdl/mpfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mpfb_ctrl.sv =====
// Controller state machine of the frame buffer: sweep, idle, execute.
// Depends on mpfb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mpfb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mpfb_pkg::dp_status_t sts_i,
  output mpfb_pkg::dp_cmd_t    cmd_o
);
  import mpfb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) state_d = sts_i.op_clear ? S_SWEEP : S_IDLE;
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.finish  = 1'b0;
    cmd_o.sweep   = 1'b0;
    unique case (state_q)
      S_SWEEP: cmd_o.sweep = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  `ASSERT_CLK(a_capture_to_exec, cmd_o.capture |=> state_q == S_EXEC, "capture not followed by execute")
  `ASSERT_CLK(a_clear_sweeps, (cmd_o.finish && sts_i.op_clear) |=> state_q == S_SWEEP, "clear did not start a sweep")
  `ASSERT_CLK(a_sweep_ends, (state_q == S_SWEEP && sts_i.sweep_last) |=> state_q == S_IDLE, "sweep did not end at last address")

endmodule

// ===== hdl/mpfb_dpath.sv =====
// Datapath of the frame buffer: page store, layer table, bounds checks, result register.
// Depends on mpfb_pkg, mpfb_ram and assert_macros.svh.
`include "assert_macros.svh"
module mpfb_dpath #(
  parameter int MAX_WIDTH  = mpfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mpfb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LAYERS = mpfb_pkg::MAX_LAYERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpfb_pkg::dp_cmd_t    cmd_i,
  output mpfb_pkg::dp_status_t sts_o,
  input  logic [7:0]           frame_width_i,
  input  logic [6:0]           frame_height_i,
  input  logic [1:0]           opcode_i,
  input  logic                 layer_visible_i,
  input  logic [7:0]           layer_index_i,
  input  logic signed [15:0]   cel_x_i,
  input  logic signed [15:0]   cel_y_i,
  input  logic [6:0]           local_x_i,
  input  logic [5:0]           local_y_i,
  input  logic [7:0]           alpha_i,
  input  logic [2:0]           page_select_i,
  input  logic [6:0]           column_select_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           page_byte_o,
  output logic [1:0]           status_o
);
  import mpfb_pkg::*;

  localparam int NUM_PAGES = (MAX_HEIGHT + 7) / 8;
  localparam int DEPTH     = MAX_WIDTH * NUM_PAGES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LAYER_AW  = $clog2(MAX_LAYERS);
  localparam int CNT_W     = $clog2(MAX_LAYERS + 1);

  // Effective frame size, clamped to the store size.
  logic [8:0] w_eff;
  logic [7:0] h_eff;
  assign w_eff = (32'(frame_width_i) < MAX_WIDTH) ? 9'(frame_width_i) : 9'(MAX_WIDTH);
  assign h_eff = (32'(frame_height_i) < MAX_HEIGHT) ? 8'(frame_height_i) : 8'(MAX_HEIGHT);

  // Draw position; bit 16 is the sign of the sum.
  logic [16:0]       x_pos, y_pos;
  logic              in_frame;
  logic [ADDR_W-1:0] draw_addr;
  assign x_pos = {cel_x_i[15], cel_x_i} + {10'b0, local_x_i};
  assign y_pos = {cel_y_i[15], cel_y_i} + {11'b0, local_y_i};
  assign in_frame = !x_pos[16] && (x_pos[15:0] < {7'b0, w_eff})
                 && !y_pos[16] && (y_pos[15:0] < {8'b0, h_eff});
  assign draw_addr = ADDR_W'(32'(y_pos[15:3]) * MAX_WIDTH + 32'(x_pos[15:0]));

  // Page read checks and row mask.
  logic              col_ok, page_ok;
  logic [5:0]        page_base;
  logic [7:0]        rows, row_mask;
  logic [ADDR_W-1:0] read_addr;
  assign col_ok    = {2'b0, column_select_i} < w_eff;
  assign page_base = {page_select_i, 3'b000};
  assign page_ok   = (32'(page_select_i) < NUM_PAGES) && ({2'b0, page_base} < h_eff);
  assign rows      = h_eff - {2'b0, page_base};
  assign read_addr = ADDR_W'(32'(page_select_i) * MAX_WIDTH + 32'(column_select_i));

  always_comb begin
    if (!page_ok) begin
      row_mask = 8'h00;
    end else if (rows >= 8'd8) begin
      row_mask = 8'hFF;
    end else begin
      row_mask = (8'h01 << rows[2:0]) - 8'h01;
    end
  end

  // Item registers.
  op_e               op_q;
  logic              vis_q, set_q, in_frame_q;
  logic [7:0]        li_q;
  logic [2:0]        bitsel_q;
  logic [ADDR_W-1:0] wr_addr_q;
  status_e           rd_status_q;
  logic [7:0]        rd_mask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_e'(opcode_i);
      vis_q       <= layer_visible_i;
      li_q        <= layer_index_i;
      set_q       <= (alpha_i != 8'h00);
      in_frame_q  <= in_frame;
      bitsel_q    <= y_pos[2:0];
      wr_addr_q   <= draw_addr;
      rd_status_q <= col_ok ? STS_OK : STS_OUTSIDE;
      rd_mask_q   <= col_ok ? row_mask : 8'h00;
    end
  end

  // Sweep counter and layer count.
  logic [ADDR_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [CNT_W-1:0]  layer_cnt_q, layer_cnt_d;
  logic              sweep_last;
  assign sweep_last = (sweep_cnt_q == ADDR_W'(DEPTH - 1));

  // Memories.
  logic              pg_we;
  logic [ADDR_W-1:0] pg_waddr;
  logic [7:0]        pg_wdata, pg_rdata;
  logic              ly_we, ly_rdata;
  logic              draw_we;

  mpfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (pg_we),
    .waddr_i(pg_waddr),
    .wdata_i(pg_wdata),
    .re_i   (cmd_i.capture),
    .raddr_i(opcode_i == OP_DRAW ? draw_addr : read_addr),
    .rdata_o(pg_rdata)
  );

  mpfb_ram #(
    .WIDTH(1),
    .DEPTH(MAX_LAYERS)
  ) u_layer_ram (
    .clk_i  (clk_i),
    .we_i   (ly_we),
    .waddr_i(layer_cnt_q[LAYER_AW-1:0]),
    .wdata_i(vis_q),
    .re_i   (cmd_i.capture),
    .raddr_i(LAYER_AW'(layer_index_i)),
    .rdata_o(ly_rdata)
  );

  // Entries at or above the layer count were never written and are not looked at.
  logic layer_ok, table_full;
  logic [7:0] bit_mask;
  assign layer_ok   = (32'(li_q) < 32'(layer_cnt_q)) && ly_rdata;
  assign table_full = (layer_cnt_q == CNT_W'(MAX_LAYERS));
  assign bit_mask   = 8'h01 << bitsel_q;

  status_e    res_status;
  logic [7:0] res_byte;

  always_comb begin
    res_status = STS_OK;
    res_byte   = 8'h00;
    ly_we      = 1'b0;
    draw_we    = 1'b0;
    case (op_q)
      OP_CLEAR: ;
      OP_DECLARE: begin
        if (table_full) begin
          res_status = STS_FULL;
        end else begin
          ly_we = cmd_i.finish;
        end
      end
      OP_DRAW: begin
        if (!layer_ok) begin
          res_status = STS_INVISIBLE;
        end else if (!in_frame_q) begin
          res_status = STS_OUTSIDE;
        end else begin
          draw_we = cmd_i.finish;
        end
      end
      OP_READ: begin
        res_status = rd_status_q;
        res_byte   = pg_rdata & rd_mask_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_i.sweep) begin
      pg_we    = 1'b1;
      pg_waddr = sweep_cnt_q;
      pg_wdata = 8'h00;
    end else begin
      pg_we    = draw_we;
      pg_waddr = wr_addr_q;
      pg_wdata = set_q ? (pg_rdata | bit_mask) : (pg_rdata & ~bit_mask);
    end
  end

  always_comb begin
    sweep_cnt_d = sweep_cnt_q;
    if (cmd_i.sweep) begin
      sweep_cnt_d = sweep_last ? '0 : sweep_cnt_q + ADDR_W'(1);
    end
    layer_cnt_d = ly_we ? layer_cnt_q + CNT_W'(1) : layer_cnt_q;
  end

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] page_byte_q;
  status_e    status_q;
  assign out_valid_d = cmd_i.finish ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      layer_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_cnt_q <= sweep_cnt_d;
      layer_cnt_q <= layer_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      page_byte_q <= res_byte;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign page_byte_o = page_byte_q;
  assign status_o    = status_q;

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.op_clear   = (op_q == OP_CLEAR);
  assign sts_o.sweep_last = sweep_last;

  `ASSERT_CLK(a_count_bound, 32'(layer_cnt_q) <= MAX_LAYERS, "layer count above table size")
  `ASSERT_CLK(a_finish_free, cmd_i.finish |-> (!out_valid_q || out_ready_i), "result register overwritten")
  `ASSERT_NEVER(a_sweep_vs_finish, cmd_i.sweep && cmd_i.finish, "sweep write collides with item write")

endmodule

// ===== hdl/mono_page_framebuffer_unit.sv =====
// Draw, declare and read are accepted in the idle state, which issues the memory reads;
// the execute state then writes back and loads the result register once that register is
// free, and only then is a new item accepted. A clear loads its result the same way, then
// a zeroing sweep of all MAX_WIDTH*ceil(MAX_HEIGHT/8) page store words (1024 by default) runs with
// no item accepted. The same sweep runs after reset; configuration writes are taken at any time.
// Async active-low reset: frame size 128 x 64, empty layer table, no result pending.
module mono_page_framebuffer_unit #(
  parameter int MAX_WIDTH  = mpfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mpfb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LAYERS = mpfb_pkg::MAX_LAYERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic               layer_visible_i,
  input  logic [7:0]         layer_index_i,
  input  logic signed [15:0] cel_x_i,
  input  logic signed [15:0] cel_y_i,
  input  logic [6:0]         local_x_i,
  input  logic [5:0]         local_y_i,
  input  logic [7:0]         alpha_i,
  input  logic [2:0]         page_select_i,
  input  logic [6:0]         column_select_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         page_byte_o,
  output logic [1:0]         status_o
);
  import mpfb_pkg::*;

  logic [7:0] frame_width_q;
  logic [6:0] frame_height_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[7:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {24'b0, frame_width_q};
      REG_FRAME_HEIGHT: prdata = {25'b0, frame_height_q};
      default:          prdata = '0;
    endcase
  end

  dp_cmd_t    cmd;
  dp_status_t sts;

  mpfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mpfb_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_LAYERS(MAX_LAYERS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .opcode_i       (opcode_i),
    .layer_visible_i(layer_visible_i),
    .layer_index_i  (layer_index_i),
    .cel_x_i        (cel_x_i),
    .cel_y_i        (cel_y_i),
    .local_x_i      (local_x_i),
    .local_y_i      (local_y_i),
    .alpha_i        (alpha_i),
    .page_select_i  (page_select_i),
    .column_select_i(column_select_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .page_byte_o    (page_byte_o),
    .status_o       (status_o)
  );

endmodule

// ===== sim/mono_page_framebuffer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of mono_page_framebuffer_unit: a directed table, then random
// draw, layer and page readback traffic checked against a behavioral frame store.
// Depends only on mpfb_pkg and the RTL of the unit.
module mono_page_framebuffer_unit_test;
  import mpfb_pkg::*;

  localparam int MAX_W          = MAX_WIDTH_DEF;
  localparam int MAX_H          = MAX_HEIGHT_DEF;
  localparam int MAX_L          = MAX_LAYERS_DEF;
  localparam int N_PAGES        = (MAX_H + 7) / 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    op_e         op;
    logic        vis;
    logic [7:0]  layer;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [6:0]  lx;
    logic [5:0]  ly;
    logic [7:0]  alpha;
    logic [2:0]  page;
    logic [6:0]  col;
  } fb_cmd_t;

  typedef struct packed {
    logic [7:0] page_byte;
    status_e    status;
  } fb_result_t;

  typedef struct {
    logic        is_cfg;
    logic        cfg_reg;
    logic [31:0] cfg_val;
    fb_cmd_t     cmd;
    logic        typed;
    fb_result_t  res;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i        = '0;
  logic        layer_visible_i = 1'b0;
  logic [7:0]  layer_index_i   = '0;
  logic [15:0] cel_x_i         = '0;
  logic [15:0] cel_y_i         = '0;
  logic [6:0]  local_x_i       = '0;
  logic [5:0]  local_y_i       = '0;
  logic [7:0]  alpha_i         = '0;
  logic [2:0]  page_select_i   = '0;
  logic [6:0]  column_select_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  page_byte_o;
  logic [1:0]  status_o;

  // Directed rows may carry a typed-in answer; it travels with the payload.
  logic        row_typed = 1'b0;
  fb_result_t  row_res   = '0;

  // Behavioral copy of the frame store, the layer table and the registers.
  logic [7:0]  page_mem [MAX_W * N_PAGES] = '{default: 8'h00};
  logic        visible_bits [MAX_L] = '{default: 1'b0};
  int          layers_declared = 0;
  logic [7:0]  cfg_width  = FRAME_WIDTH_RST;
  logic [6:0]  cfg_height = FRAME_HEIGHT_RST;

  fb_result_t  pending_results[$];
  dir_row_t    dir_tab[$];
  int          items_in     = 0;
  int          results_out  = 0;
  int          err_cnt      = 0;
  int          stall_cycles = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_req     = 1'b0;

  mono_page_framebuffer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .layer_visible_i(layer_visible_i),
    .layer_index_i  (layer_index_i),
    .cel_x_i        (cel_x_i),
    .cel_y_i        (cel_y_i),
    .local_x_i      (local_x_i),
    .local_y_i      (local_y_i),
    .alpha_i        (alpha_i),
    .page_select_i  (page_select_i),
    .column_select_i(column_select_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .page_byte_o    (page_byte_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one operation to the frame store copy and returns its answer.
  function automatic fb_result_t frame_op_result(fb_cmd_t c);
    fb_result_t r;
    int w, h, x, y, rows;
    logic [7:0] mask;
    r.page_byte = '0;
    r.status    = STS_OK;
    w = (int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width);
    h = (int'(cfg_height) > MAX_H) ? MAX_H : int'(cfg_height);
    case (c.op)
      OP_CLEAR: begin
        foreach (page_mem[i]) page_mem[i] = '0;
      end
      OP_DECLARE: begin
        if (layers_declared >= MAX_L) begin
          r.status = STS_FULL;
        end else begin
          visible_bits[layers_declared] = c.vis;
          layers_declared++;
        end
      end
      OP_DRAW: begin
        if (int'(c.layer) >= layers_declared || !visible_bits[c.layer]) begin
          r.status = STS_INVISIBLE;
        end else begin
          x = int'($signed(c.cx)) + int'(c.lx);
          y = int'($signed(c.cy)) + int'(c.ly);
          if (x < 0 || y < 0 || x >= w || y >= h) begin
            r.status = STS_OUTSIDE;
          end else begin
            page_mem[(y / 8) * MAX_W + x][y % 8] = (c.alpha != 8'd0);
          end
        end
      end
      default: begin
        if (int'(c.col) >= w) begin
          r.status = STS_OUTSIDE;
        end else if (int'(c.page) < N_PAGES && int'(c.page) * 8 < h) begin
          // Rows below the frame height are masked off in a partial page.
          rows = h - int'(c.page) * 8;
          mask = (rows >= 8) ? 8'hFF : 8'((1 << rows) - 1);
          r.page_byte = page_mem[int'(c.page) * MAX_W + int'(c.col)] & mask;
        end
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t op_row(op_e op);
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_reg = REG_FRAME_WIDTH;
    r.cfg_val = '0;
    r.cmd     = '0;
    r.cmd.op  = op;
    r.typed   = 1'b0;
    r.res     = '0;
    return r;
  endfunction

  function automatic dir_row_t decl_row(logic vis);
    dir_row_t r;
    r = op_row(OP_DECLARE);
    r.cmd.vis = vis;
    return r;
  endfunction

  function automatic dir_row_t draw_row(logic [7:0] layer, logic [15:0] cx, logic [15:0] cy,
                                        logic [6:0] lx, logic [5:0] ly, logic [7:0] alpha);
    dir_row_t r;
    r = op_row(OP_DRAW);
    r.cmd.layer = layer;
    r.cmd.cx    = cx;
    r.cmd.cy    = cy;
    r.cmd.lx    = lx;
    r.cmd.ly    = ly;
    r.cmd.alpha = alpha;
    return r;
  endfunction

  function automatic dir_row_t read_row(logic [2:0] page, logic [6:0] col);
    dir_row_t r;
    r = op_row(OP_READ);
    r.cmd.page = page;
    r.cmd.col  = col;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [31:0] val);
    dir_row_t r;
    r = op_row(OP_READ);
    r.is_cfg  = 1'b1;
    r.cfg_reg = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic dir_row_t known(dir_row_t r, logic [7:0] pb, status_e st);
    r.typed         = 1'b1;
    r.res.page_byte = pb;
    r.res.status    = st;
    return r;
  endfunction

  // Random item: every field but the opcode gets random content, positions mostly near the frame.
  function automatic fb_cmd_t rand_cmd(op_e op, bit any_layer);
    fb_cmd_t c;
    int top;
    top      = (layers_declared < 255) ? layers_declared + 1 : 255;
    c.op     = op;
    c.vis    = ($urandom_range(99) < 80);
    if (any_layer || $urandom_range(4) == 0) begin
      c.layer = 8'($urandom);
    end else begin
      c.layer = 8'($urandom_range(0, top));
    end
    if ($urandom_range(6) == 0) begin
      c.cx = 16'($urandom);
      c.cy = 16'($urandom);
    end else begin
      c.cx = 16'($urandom_range(0, 40)) - 16'd24;
      c.cy = 16'($urandom_range(0, 24)) - 16'd12;
    end
    c.lx    = 7'($urandom);
    c.ly    = 6'($urandom);
    c.alpha = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    c.page  = 3'($urandom);
    c.col   = 7'($urandom);
    return c;
  endfunction

  task automatic send_item(input fb_cmd_t c, input logic typed = 1'b0,
                           input fb_result_t res = '0);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= c.op;
    layer_visible_i <= c.vis;
    layer_index_i   <= c.layer;
    cel_x_i         <= c.cx;
    cel_y_i         <= c.cy;
    local_x_i       <= c.lx;
    local_y_i       <= c.ly;
    alpha_i         <= c.alpha;
    page_select_i   <= c.page;
    column_select_i <= c.col;
    row_typed       <= typed;
    row_res         <= res;
    do @(posedge clk_i); while (!in_ready_o);
    items_in++;
  endtask

  // Stops offering items until every result sent so far has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_out != items_in) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FRAME_WIDTH) begin
      cfg_width = val[7:0];
    end else begin
      cfg_height = val[6:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
    drain_results();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic run_mix(input int n, input int p_decl, input bit any_layer);
    int r;
    op_e op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        op = OP_CLEAR;
      end else if (r < 2 + p_decl) begin
        op = OP_DECLARE;
      end else if (r < 60) begin
        op = OP_DRAW;
      end else begin
        op = OP_READ;
      end
      send_item(rand_cmd(op, any_layer));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= !gaps_on || ($urandom_range(99) >= 28);
    end
  end

  // Scoreboard and watchdog; expectations are queued in the order items are taken.
  always @(posedge clk_i) begin : scoreboard
    fb_cmd_t seen;
    fb_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stall_cycles);
        $display("[mono_page_framebuffer_unit] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (out_valid_o && out_ready_i) begin
        results_out++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: result with nothing expected: page_byte %02h status %0d",
                     $time, page_byte_o, status_o);
          end
        end else begin
          want = pending_results.pop_front();
          if (page_byte_o !== want.page_byte || status_o !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: mismatch: page_byte exp %02h got %02h, status exp %0d got %0d",
                       $time, want.page_byte, page_byte_o, want.status, status_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.op    = op_e'(opcode_i);
        seen.vis   = layer_visible_i;
        seen.layer = layer_index_i;
        seen.cx    = cel_x_i;
        seen.cy    = cel_y_i;
        seen.lx    = local_x_i;
        seen.ly    = local_y_i;
        seen.alpha = alpha_i;
        seen.page  = page_select_i;
        seen.col   = column_select_i;
        want = frame_op_result(seen);
        if (row_typed) want = row_res;
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    // Reset state: empty store, no layers, frame 128 x 64.
    dir_tab.push_back(known(read_row(3'd0, 7'd0), 8'h00, STS_OK));
    dir_tab.push_back(known(read_row(3'd7, 7'd127), 8'h00, STS_OK));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h0000, 7'd0, 6'd0, 8'hFF),
                            8'h00, STS_INVISIBLE));
    dir_tab.push_back(known(decl_row(1'b1), 8'h00, STS_OK));
    dir_tab.push_back(known(decl_row(1'b0), 8'h00, STS_OK));
    dir_tab.push_back(known(draw_row(8'd1, 16'h0000, 16'h0000, 7'd0, 6'd0, 8'h01),
                            8'h00, STS_INVISIBLE));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h0000, 7'd0, 6'd0, 8'hFF),
                            8'h00, STS_OK));
    dir_tab.push_back(known(read_row(3'd0, 7'd0), 8'h01, STS_OK));
    dir_tab.push_back(known(draw_row(8'd0, 16'h8000, 16'h0000, 7'd127, 6'd0, 8'h01),
                            8'h00, STS_OUTSIDE));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h7FFF, 7'd0, 6'd63, 8'h01),
                            8'h00, STS_OUTSIDE));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h0000, 7'd127, 6'd63, 8'h80),
                            8'h00, STS_OK));
    dir_tab.push_back(known(read_row(3'd7, 7'd127), 8'h80, STS_OK));
    // Negative cel offset lands on the top left pixel; zero alpha clears it.
    dir_tab.push_back(draw_row(8'd0, 16'hFFFF, 16'hFFC1, 7'd1, 6'd63, 8'h00));
    dir_tab.push_back(read_row(3'd0, 7'd0));
    dir_tab.push_back(known(draw_row(8'd255, 16'h0000, 16'h0000, 7'd0, 6'd0, 8'h01),
                            8'h00, STS_INVISIBLE));
    dir_tab.push_back(known(op_row(OP_CLEAR), 8'h00, STS_OK));
    dir_tab.push_back(known(read_row(3'd7, 7'd127), 8'h00, STS_OK));
    // Zero width leaves no column in the frame.
    dir_tab.push_back(cfg_row(REG_FRAME_WIDTH, 32'd0));
    dir_tab.push_back(known(read_row(3'd0, 7'd0), 8'h00, STS_OUTSIDE));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h0000, 7'd0, 6'd0, 8'h01),
                            8'h00, STS_OUTSIDE));
    // Width above the maximum is clamped; zero height reads as an empty page.
    dir_tab.push_back(cfg_row(REG_FRAME_WIDTH, 32'd255));
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 32'd0));
    dir_tab.push_back(known(read_row(3'd0, 7'd5), 8'h00, STS_OK));
    // Eleven rows: page 1 is partial, page 2 lies wholly below the frame.
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 32'd11));
    dir_tab.push_back(draw_row(8'd0, 16'h0000, 16'h0008, 7'd0, 6'd2, 8'h01));
    dir_tab.push_back(known(draw_row(8'd0, 16'h0000, 16'h0008, 7'd0, 6'd3, 8'h01),
                            8'h00, STS_OUTSIDE));
    dir_tab.push_back(read_row(3'd1, 7'd0));
    dir_tab.push_back(known(read_row(3'd2, 7'd0), 8'h00, STS_OK));
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 32'd127));
    dir_tab.push_back(draw_row(8'd0, 16'h0000, 16'd60, 7'd0, 6'd3, 8'h01));
    dir_tab.push_back(read_row(3'd7, 7'd0));
    dir_tab.push_back(read_row(3'd1, 7'd0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        write_reg(dir_tab[i].cfg_reg, dir_tab[i].cfg_val);
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    set_frame(32'd128, 32'd64);
    // The receiver holds off for a while so the unit backs up into its input.
    hold_req = 1'b1;
    run_mix(250, 12, 1'b0);

    set_frame($urandom_range(1, 128), $urandom_range(1, 64));
    gaps_on = 1'b0;
    run_mix(150, 12, 1'b0);
    gaps_on = 1'b1;

    // Fill the layer table, then declare past its end.
    while (layers_declared < MAX_L) begin
      if ($urandom_range(99) < 65) begin
        send_item(rand_cmd(OP_DECLARE, 1'b0));
      end else if ($urandom_range(1) == 0) begin
        send_item(rand_cmd(OP_DRAW, 1'b0));
      end else begin
        send_item(rand_cmd(OP_READ, 1'b0));
      end
    end
    repeat (5) send_item(rand_cmd(OP_DECLARE, 1'b1));

    set_frame(32'd255, 32'd127);
    run_mix(250, 3, 1'b1);
    set_frame(32'd1, 32'd1);
    run_mix(40, 3, 1'b1);
    set_frame(32'd0, 32'd0);
    run_mix(20, 3, 1'b1);
    set_frame($urandom_range(1, 128), $urandom_range(1, 64));
    run_mix(150, 3, 1'b1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("[mono_page_framebuffer_unit] OK");
    end else begin
      $display("[mono_page_framebuffer_unit] ERROR");
    end
    $finish;
  end

endmodule
